// ----- design/tci_pkg.sv -----
`timescale 1ns / 1ps

package tci_pkg;

  // Field widths fixed by the interface.
  localparam int MODE_W     = 2;
  localparam int TIME_W     = 20;
  localparam int THRUST_W   = 24;
  localparam int MASS_W     = 24;
  localparam int IMP_W      = 52;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_BIT    = 2;

  // Shared multiplier takes a 25-bit thrust sum or magnitude and a 20-bit time.
  localparam int MUL_A_W    = THRUST_W + 1;
  localparam int PROD_W     = MUL_A_W + TIME_W;

  // The divider sees a 44-bit dividend and always yields a 24-bit quotient.
  localparam int DIVIDEND_W = THRUST_W + TIME_W;
  localparam int DIV_STEPS  = THRUST_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Operation codes on the mode field.
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Status codes returned with every result word.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_INC  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DATA  = 2'd3;

  // Register index as decoded from paddr.
  localparam logic REG_TOTAL_MASS = 1'b0;
  localparam logic REG_PROP_MASS  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_APP_MUL,
    S_APP_ACC,
    S_SCAN_ISSUE,
    S_SCAN,
    S_THR_MUL,
    S_THR_DIV0,
    S_THR_DIV,
    S_MASS_SET,
    S_MASS_MUL,
    S_MASS_DIV0,
    S_MASS_DIV,
    S_MASS_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [TIME_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/tci_ram.sv -----
`timescale 1ns / 1ps

module tci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tci_div.sv -----
`timescale 1ns / 1ps

module tci_div import tci_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // that the quotient fits in DIV_STEPS bits, so the upper dividend bits
  // already form a partial remainder below the divisor.
  logic [TIME_W-1:0]    rem;
  logic [DIV_STEPS-1:0] qsh;
  logic [TIME_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [TIME_W:0] trial;
  logic [TIME_W:0] diff;
  logic            ge;

  assign trial = {rem, qsh[DIV_STEPS-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[DIVIDEND_W-1:DIV_STEPS];
      qsh <= req.dividend[DIV_STEPS-1:0];
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      qsh <= {qsh[DIV_STEPS-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = qsh;

endmodule

// ----- design/thrust_curve_interpolator.sv -----
`timescale 1ns / 1ps

// Thrust curve interpolator.
// The block stores a motor thrust curve of up to MAX_POINTS points and answers
// one result word for every input word on the in channel (mode, time_ticks,
// thrust_value). Mode 0 appends a point and adds its trapezoid to a saturating
// impulse total, mode 1 returns interpolated thrust and motor mass at a time,
// mode 2 clears the curve. The out channel carries thrust_out, mass_out, the
// current total_impulse and points_held, and a status code.
// A word is accepted while in_stall is low, which is the case only out of reset
// and when the sequencer is idle. In a query the segment search reads the point
// memory one entry per cycle, and two 24-step divisions share one restoring
// divider behind one shared multiplier. The next word can be accepted as soon
// as a result sits in the output register; if out_stall holds that result, the
// following word finishes its work and then waits until the register frees.
// Reset clears the curve, the impulse total and both mass registers, and
// empties the output register. Total and propellant mass are written through
// the APB port at addresses 0 and 4; the user must write them only while the
// block is idle, as the block itself does not enforce it.
module thrust_curve_interpolator import tci_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [MODE_W-1:0]            mode,
  input  logic [TIME_W-1:0]            time_ticks,
  input  logic [THRUST_W-1:0]          thrust_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [THRUST_W-1:0]          thrust_out,
  output logic [MASS_W-1:0]            mass_out,
  output logic [IMP_W-1:0]             total_impulse,
  output logic [$clog2(MAX_POINTS+1)-1:0] points_held,
  output logic [STATUS_W-1:0]          status
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  // Control state.
  state_t            state;
  state_t            state_next;
  logic [MASS_W-1:0] total_mass;
  logic [MASS_W-1:0] propellant_mass;
  logic [CNT_W-1:0]  point_count;
  logic [IMP_W-1:0]  impulse_sum;

  // Latched input word.
  logic [MODE_W-1:0]   op_mode;
  logic [TIME_W-1:0]   op_time;
  logic [THRUST_W-1:0] op_thrust;

  // Copies of the first and last stored points, valid while the curve is
  // not empty.
  logic [TIME_W-1:0]   first_time;
  logic [THRUST_W-1:0] first_thrust;
  logic [TIME_W-1:0]   last_time;
  logic [THRUST_W-1:0] last_thrust;

  // Segment search.
  logic [IDX_W-1:0]    scan_addr;
  logic [TIME_W-1:0]   prev_time;
  logic [THRUST_W-1:0] prev_thrust;
  logic [TIME_W-1:0]   rd_time;
  logic [THRUST_W-1:0] rd_thrust;

  // Shared multiplier and divider operands.
  logic [MUL_A_W-1:0]  mul_a;
  logic [TIME_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;
  logic [TIME_W-1:0]   divisor;
  logic                seg_neg;
  logic [THRUST_W-1:0] seg_base;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Result assembly.
  logic [THRUST_W-1:0] thr_res;
  logic [MASS_W-1:0]   mass_res;
  logic [MASS_W-1:0]   burnt;
  logic [STATUS_W-1:0] res_status;

  logic                accept;
  logic                out_free;
  logic                cfg_we;
  logic                cnt_full;
  logic                cnt_empty;
  logic                append_ok;
  logic                ram_we;
  logic                scan_hit;
  logic                dy_neg;
  logic [THRUST_W-1:0] dy_mag;
  logic [IMP_W:0]      imp_sum;
  logic [THRUST_W-1:0] seg_value;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign in_stall  = rst || (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign cnt_full  = point_count >= CNT_W'(MAX_POINTS);
  assign cnt_empty = (point_count == '0);
  assign append_ok = !cnt_full && (cnt_empty || (op_time > last_time));
  assign ram_we    = (state == S_DISPATCH) && (op_mode == MODE_APPEND) && append_ok;

  // The search walks the curve from the first point; since the query time is
  // inside the curve, the first stored time above it closes the segment.
  assign scan_hit  = rd_time > op_time;
  assign dy_neg    = rd_thrust < prev_thrust;
  assign dy_mag    = dy_neg ? (prev_thrust - rd_thrust) : (rd_thrust - prev_thrust);

  // The half trapezoid area is at most 44 bits; one extra bit catches overflow.
  assign imp_sum   = {1'b0, impulse_sum} + (IMP_W+1)'(prod[PROD_W-1:1]);

  assign seg_value = seg_neg ? (seg_base - div_rsp.quotient)
                             : (seg_base + div_rsp.quotient);

  assign div_req.start    = (state == S_THR_DIV0) || (state == S_MASS_DIV0);
  assign div_req.dividend = prod[DIVIDEND_W-1:0];
  assign div_req.divisor  = divisor;

  tci_ram #(.WIDTH(TIME_W), .DEPTH(MAX_POINTS)) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata (op_time),
    .raddr (scan_addr),
    .rdata (rd_time)
  );

  tci_ram #(.WIDTH(THRUST_W), .DEPTH(MAX_POINTS)) u_thrust_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata (op_thrust),
    .raddr (scan_addr),
    .rdata (rd_thrust)
  );

  tci_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Register reads.
  always_comb begin
    case (paddr[REG_BIT])
      REG_TOTAL_MASS: prdata = CFG_DATA_W'(total_mass);
      REG_PROP_MASS:  prdata = CFG_DATA_W'(propellant_mass);
      default:        prdata = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_mode)
          MODE_APPEND: begin
            state_next = (append_ok && !cnt_empty) ? S_APP_MUL : S_DONE;
          end
          MODE_QUERY: begin
            if (cnt_empty) begin
              state_next = S_DONE;
            end else if (op_time < first_time) begin
              state_next = S_THR_MUL;
            end else if (op_time >= last_time) begin
              state_next = S_MASS_SET;
            end else begin
              state_next = S_SCAN_ISSUE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_APP_MUL:    state_next = S_APP_ACC;
      S_APP_ACC:    state_next = S_DONE;
      S_SCAN_ISSUE: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_THR_MUL;
        end
      end
      S_THR_MUL:    state_next = S_THR_DIV0;
      S_THR_DIV0:   state_next = S_THR_DIV;
      S_THR_DIV: begin
        if (div_rsp.done) begin
          state_next = S_MASS_SET;
        end
      end
      S_MASS_SET:   state_next = (op_time >= last_time) ? S_MASS_FIN : S_MASS_MUL;
      S_MASS_MUL:   state_next = S_MASS_DIV0;
      S_MASS_DIV0:  state_next = S_MASS_DIV;
      S_MASS_DIV: begin
        if (div_rsp.done) begin
          state_next = S_MASS_FIN;
        end
      end
      S_MASS_FIN:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      total_mass      <= '0;
      propellant_mass <= '0;
      point_count     <= '0;
      impulse_sum     <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (paddr[REG_BIT])
          REG_TOTAL_MASS: total_mass      <= pwdata[MASS_W-1:0];
          REG_PROP_MASS:  propellant_mass <= pwdata[MASS_W-1:0];
          default: ;
        endcase
      end
      if (state == S_DISPATCH) begin
        if (op_mode == MODE_CLEAR) begin
          point_count <= '0;
          impulse_sum <= '0;
        end else if (ram_we) begin
          point_count <= point_count + 1'b1;
        end
      end
      if (state == S_APP_ACC) begin
        impulse_sum <= imp_sum[IMP_W] ? {IMP_W{1'b1}} : imp_sum[IMP_W-1:0];
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      op_mode   <= mode;
      op_time   <= time_ticks;
      op_thrust <= thrust_value;
    end
    case (state)
      S_DISPATCH: begin
        thr_res    <= '0;
        mass_res   <= '0;
        res_status <= ST_OK;
        scan_addr  <= '0;
        case (op_mode)
          MODE_APPEND: begin
            if (cnt_full) begin
              res_status <= ST_FULL;
            end else if (!append_ok) begin
              res_status <= ST_NOT_INC;
            end else begin
              mul_a        <= MUL_A_W'(last_thrust) + MUL_A_W'(op_thrust);
              mul_b        <= op_time - last_time;
              last_time    <= op_time;
              last_thrust  <= op_thrust;
              if (cnt_empty) begin
                first_time   <= op_time;
                first_thrust <= op_thrust;
              end
            end
          end
          MODE_QUERY: begin
            if (cnt_empty) begin
              res_status <= ST_NO_DATA;
            end else if (op_time < first_time) begin
              // Ramp from zero at time zero up to the first point.
              mul_a    <= MUL_A_W'(first_thrust);
              mul_b    <= op_time;
              divisor  <= first_time;
              seg_neg  <= 1'b0;
              seg_base <= '0;
            end else if (op_time == last_time) begin
              thr_res <= last_thrust;
            end
          end
          default: ;
        endcase
      end
      S_SCAN_ISSUE: begin
        scan_addr <= scan_addr + 1'b1;
      end
      S_SCAN: begin
        scan_addr   <= scan_addr + 1'b1;
        prev_time   <= rd_time;
        prev_thrust <= rd_thrust;
        if (scan_hit) begin
          mul_a    <= MUL_A_W'(dy_mag);
          mul_b    <= op_time - prev_time;
          divisor  <= rd_time - prev_time;
          seg_neg  <= dy_neg;
          seg_base <= prev_thrust;
        end
      end
      S_THR_DIV: begin
        if (div_rsp.done) begin
          thr_res <= seg_value;
        end
      end
      S_MASS_SET: begin
        // At or past burnout the whole propellant is gone.
        burnt   <= propellant_mass;
        mul_a   <= MUL_A_W'(propellant_mass);
        mul_b   <= op_time;
        divisor <= last_time;
      end
      S_MASS_DIV: begin
        if (div_rsp.done) begin
          burnt <= div_rsp.quotient;
        end
      end
      S_MASS_FIN: begin
        mass_res <= (burnt >= total_mass) ? '0 : (total_mass - burnt);
      end
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      thrust_out    <= thr_res;
      mass_out      <= mass_res;
      total_impulse <= impulse_sum;
      points_held   <= point_count;
      status        <= res_status;
    end
  end

endmodule

// ----- design/tci_checker.sv -----
`timescale 1ns / 1ps

module tci_checker import tci_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [THRUST_W-1:0]             thrust_out,
  input logic [MASS_W-1:0]               mass_out,
  input logic [$clog2(MAX_POINTS+1)-1:0] points_held,
  input logic [STATUS_W-1:0]             status
);

  // An accepted word keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after an accept");

  // A held result word keeps its payload.
  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(thrust_out) && $stable(mass_out)
      && $stable(status))
    else $error("stalled result word changed");

  // A query on an empty curve reports nothing stored and zero values.
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_DATA |-> points_held == 0 && thrust_out == 0
      && mass_out == 0)
    else $error("no-data result with stored points or nonzero values");

  // A full table rejection only happens with every slot in use.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> points_held == MAX_POINTS)
    else $error("table full reported with free slots");

endmodule

bind thrust_curve_interpolator tci_checker #(.MAX_POINTS(MAX_POINTS)) u_tci_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .thrust_out  (thrust_out),
  .mass_out    (mass_out),
  .points_held (points_held),
  .status      (status)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the thrust curve interpolator.
// A scoreboard class keeps its own copy of the curve, the impulse total and the
// two mass registers. Every word accepted on the in channel is run through that
// copy, and the expected result word is queued. Every word accepted on the out
// channel is compared field by field with the oldest queued word.
module tb_top;
  import tci_pkg::*;

  localparam int MAX_PTS     = 64;
  localparam int PTS_W       = $clog2(MAX_PTS + 1);
  localparam int TIME_MAX    = (1 << TIME_W) - 1;
  localparam int CYCLE_LIMIT = 2_000_000;

  // The mode field has one code that the block does not use.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Register byte addresses on the configuration port.
  localparam logic [PADDR_W-1:0] ADDR_TOTAL_MASS = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_PROP_MASS  = 3'd4;

  localparam logic [IMP_W-1:0] IMP_MAX = {IMP_W{1'b1}};

  typedef struct packed {
    logic [THRUST_W-1:0] thrust;
    logic [MASS_W-1:0]   mass;
    logic [IMP_W-1:0]    impulse;
    logic [PTS_W-1:0]    points;
    logic [STATUS_W-1:0] status;
  } curve_result_t;

  // Scoreboard: a bit-true model of the curve store plus the queue of result
  // words that are still owed by the block.
  class curve_ledger;
    logic [TIME_W-1:0]   pt_time   [MAX_PTS];
    logic [THRUST_W-1:0] pt_thrust [MAX_PTS];
    int unsigned         npts = 0;
    logic [IMP_W-1:0]    impulse = '0;
    logic [MASS_W-1:0]   mass_total = '0;
    logic [MASS_W-1:0]   mass_prop = '0;
    curve_result_t       awaited[$];
    int unsigned errors = 0, checked = 0;
    int unsigned n_stored = 0, n_full = 0, n_not_inc = 0, n_query = 0;
    int unsigned n_no_data = 0, n_clear = 0, n_unused = 0;

    function void set_reg(logic idx, logic [MASS_W-1:0] value);
      if (idx == REG_TOTAL_MASS) mass_total = value;
      else mass_prop = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function logic [TIME_W-1:0] last_time();
      return pt_time[npts - 1];
    endfunction

    // Linear interpolation between stored points; ramps up from zero before
    // the first point and drops to zero past the last one.
    function logic [THRUST_W-1:0] thrust_at(logic [TIME_W-1:0] t);
      longint unsigned u;
      longint lo, hi, dx, off;
      int unsigned last;
      int i;
      last = npts - 1;
      if (t < pt_time[0]) begin
        u = pt_thrust[0];
        return (u * t) / pt_time[0];
      end
      if (t > pt_time[last]) return '0;
      if (t == pt_time[last]) return pt_thrust[last];
      for (i = 1; i < npts; i++) begin
        if (pt_time[i] > t && pt_time[i-1] <= t) begin
          lo = pt_thrust[i-1];
          hi = pt_thrust[i];
          dx = pt_time[i];
          dx = dx - pt_time[i-1];
          off = t;
          off = off - pt_time[i-1];
          // Signed division truncates toward zero on a falling segment.
          return lo + ((hi - lo) * off) / dx;
        end
      end
      return '0;
    endfunction

    // Propellant burns linearly up to the last point's time.
    function logic [MASS_W-1:0] mass_at(logic [TIME_W-1:0] t);
      longint unsigned burnt, burn;
      burn = pt_time[npts - 1];
      burnt = mass_prop;
      if (t < burn) burnt = (burnt * t) / burn;
      if (burnt >= mass_total) return '0;
      return mass_total - burnt;
    endfunction

    function void note_input(logic [MODE_W-1:0] m, logic [TIME_W-1:0] t,
                             logic [THRUST_W-1:0] thr);
      curve_result_t   r;
      longint unsigned area, sum;
      r = '0;
      r.status = ST_OK;
      case (m)
        MODE_APPEND: begin
          if (npts >= MAX_PTS) begin
            r.status = ST_FULL;
            n_full++;
          end else if (npts > 0 && t <= pt_time[npts - 1]) begin
            r.status = ST_NOT_INC;
            n_not_inc++;
          end else begin
            if (npts > 0) begin
              area = pt_thrust[npts - 1];
              area = (area + thr) * (t - pt_time[npts - 1]) / 2;
              sum = impulse;
              sum = sum + area;
              impulse = (sum > IMP_MAX) ? IMP_MAX : sum[IMP_W-1:0];
            end
            pt_time[npts] = t;
            pt_thrust[npts] = thr;
            npts++;
            n_stored++;
          end
        end
        MODE_QUERY: begin
          n_query++;
          if (npts == 0) begin
            r.status = ST_NO_DATA;
            n_no_data++;
          end else begin
            r.thrust = thrust_at(t);
            r.mass = mass_at(t);
          end
        end
        MODE_CLEAR: begin
          npts = 0;
          impulse = '0;
          n_clear++;
        end
        default: n_unused++;
      endcase
      r.impulse = impulse;
      r.points = npts;
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(curve_result_t got);
      curve_result_t want;
      if (awaited.size() == 0) begin
        $error("result word with nothing outstanding: thrust_out %0d status %0d",
               got.thrust, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("thrust_out", want.thrust, got.thrust);
      compare_field("mass_out", want.mass, got.mass);
      compare_field("total_impulse", want.impulse, got.impulse);
      compare_field("points_held", want.points, got.points);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;
  logic                  pready;
  logic                  in_valid, in_stall;
  logic [MODE_W-1:0]     mode;
  logic [TIME_W-1:0]     time_ticks;
  logic [THRUST_W-1:0]   thrust_value;
  logic                  out_valid, out_stall;
  logic [THRUST_W-1:0]   thrust_out;
  logic [MASS_W-1:0]     mass_out;
  logic [IMP_W-1:0]      total_impulse;
  logic [PTS_W-1:0]      points_held;
  logic [STATUS_W-1:0]   status;

  curve_ledger ledger = new();

  // Knobs shared between the stimulus and the receiver process.
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int unsigned words_sent = 0;
  int unsigned hold_count = 0;
  int unsigned cycle_count = 0;

  thrust_curve_interpolator #(.MAX_POINTS(MAX_PTS)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .time_ticks(time_ticks), .thrust_value(thrust_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .thrust_out(thrust_out), .mass_out(mass_out), .total_impulse(total_impulse),
    .points_held(points_held), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. The limit is far above the slowest legal run, even with every query
  // scanning a full table.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Receiver. Requests and the stall rate are picked up at the rising edge,
  // where the stimulus never writes them, and out_stall changes at the falling
  // edge. A long hold-off is counted down here, cycle by cycle, so the
  // sender keeps offering words while the output side is blocked.
  initial begin
    int pct_now;
    int hold_left;
    pct_now = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      pct_now = stall_pct;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
        hold_count++;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < pct_now);
      end
    end
  end

  // Output monitor: a word moves when out_valid is high and out_stall is low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      ledger.check_result(curve_result_t'{thrust_out, mass_out, total_impulse,
                                          points_held, status});
  end

  // Sends one word. Called at a falling edge and returns at a falling edge with
  // in_valid still high, so back-to-back words keep valid up without a dip.
  // The expected result is worked out at the edge where the word is taken.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t,
                           input logic [THRUST_W-1:0] thr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode = m;
    time_ticks = t;
    thrust_value = thr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_input(m, t, thr);
    words_sent++;
    @(negedge clk);
  endtask

  // Drops in_valid and waits until every owed result word has been taken.
  task automatic pause_until_drained();
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  // One APB transfer. psel stays high afterwards so that transfers can follow
  // each other; the caller drops it at the end of a burst.
  task automatic apb_cycle(input logic wr, input logic [PADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] wdata,
                           output logic [CFG_DATA_W-1:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
  endtask

  // Writes a mass register, reads it back, and updates the scoreboard copy.
  task automatic write_reg(input logic idx, input logic [PADDR_W-1:0] addr,
                           input logic [MASS_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    apb_cycle(1'b1, addr, CFG_DATA_W'(value), rd);
    apb_cycle(1'b0, addr, '0, rd);
    if (rd !== CFG_DATA_W'(value)) begin
      $error("register readback at %0d: expected %0d, got %0d", addr, value, rd);
      ledger.errors++;
    end
    ledger.set_reg(idx, value);
  endtask

  task automatic write_config(input logic [MASS_W-1:0] tot, input logic [MASS_W-1:0] prop);
    write_reg(REG_TOTAL_MASS, ADDR_TOTAL_MASS, tot);
    write_reg(REG_PROP_MASS, ADDR_PROP_MASS, prop);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [THRUST_W-1:0] pick_thrust();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(4095);
      default: return $urandom;
    endcase
  endfunction

  // Query times cluster on the interesting spots: right on a stored point,
  // one tick to either side, inside the curve, past the end, and the extremes.
  function automatic logic [TIME_W-1:0] pick_query_time();
    logic [TIME_W-1:0] last, pt;
    if (ledger.npts == 0) return $urandom;
    last = ledger.last_time();
    pt = ledger.pt_time[$urandom_range(ledger.npts - 1)];
    case ($urandom_range(7))
      0: return pt;
      1: return (pt == '1) ? pt - 1'b1 : pt + 1'b1;
      2: return (pt == '0) ? pt : pt - 1'b1;
      3: return $urandom_range(last);
      4: return (last == '1) ? last : $urandom_range(TIME_MAX, last + 1);
      5: return '1;
      6: return '0;
      default: return $urandom;
    endcase
  endfunction

  // A well-formed curve with random content: usually a clear, then points with
  // rising times and queries sprinkled in between. About one append in twelve
  // on a short curve goes back in time, and a long curve only moves forward, so
  // it always fills the table and may run past its size.
  task automatic curve_session(input bit long_one);
    int unsigned       goal, stepmax, k, nq;
    logic [TIME_W-1:0] prev, t;
    if (ledger.npts == 0 || $urandom_range(99) < 85)
      send_word(MODE_CLEAR, $urandom, $urandom);
    goal = long_one ? $urandom_range(70, MAX_PTS) : $urandom_range(10, 1);
    prev = (ledger.npts == 0) ? '0 : ledger.last_time();
    stepmax = (TIME_MAX - prev) / (goal + 1);
    if (stepmax == 0) stepmax = 1;
    for (k = 0; k < goal; k++) begin
      if (ledger.npts == 0)
        t = ($urandom_range(3) == 0) ? '0 : $urandom_range(stepmax, 1);
      else if (!long_one && $urandom_range(11) == 0)
        t = prev - $urandom_range((prev < 50) ? prev : 50);
      else
        t = prev + $urandom_range(stepmax, 1);
      send_word(MODE_APPEND, t, pick_thrust());
      if (ledger.npts != 0) prev = ledger.last_time();
      nq = long_one ? ($urandom_range(3) == 0) : $urandom_range(2);
      repeat (nq) send_word(MODE_QUERY, pick_query_time(), $urandom);
      if ($urandom_range(39) == 0) send_word(MODE_UNUSED, $urandom, $urandom);
    end
  endtask

  // One idling phase: settle, load new masses, then random curves until the
  // word budget is spent. Midway the sender stops and lets the block drain.
  task automatic run_phase(input int sp, input int rp, input logic [MASS_W-1:0] tot,
                           input logic [MASS_W-1:0] prop, input int unsigned budget,
                           input bit squeeze, input bit start_long);
    int unsigned stop_at, sess;
    pause_until_drained();
    repeat (4) @(negedge clk);
    write_config(tot, prop);
    send_idle_pct = sp;
    stall_pct = rp;
    stop_at = words_sent + budget;
    sess = 0;
    if (squeeze) hold_req = 400;
    while (words_sent < stop_at) begin
      curve_session((sess == 0 && start_long) || $urandom_range(7) == 0);
      if (sess == 3) pause_until_drained();
      sess++;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    mode = MODE_CLEAR;
    time_ticks = '0;
    thrust_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty-curve queries, the unused mode, a first point that
    // is not at time zero, rejected appends (equal and earlier time), rising
    // and falling segments, queries before, on, between and after the points,
    // field extremes, and a curve whose only point sits at time zero so the
    // burn time is zero.
    write_config(24'd20000, 24'd7000);
    send_word(MODE_QUERY, '0, '0);
    send_word(MODE_QUERY, '1, '1);
    send_word(MODE_UNUSED, '1, '1);
    send_word(MODE_CLEAR, '0, '0);
    send_word(MODE_APPEND, 20'd1000, 24'd1600);
    send_word(MODE_QUERY, 20'd0, '0);
    send_word(MODE_QUERY, 20'd500, '0);
    send_word(MODE_APPEND, 20'd1000, 24'd5);
    send_word(MODE_APPEND, 20'd999, 24'd5);
    send_word(MODE_APPEND, 20'd3000, '1);
    send_word(MODE_APPEND, 20'd6000, '0);
    send_word(MODE_QUERY, 20'd2000, '0);
    send_word(MODE_QUERY, 20'd4500, '0);
    send_word(MODE_QUERY, 20'd6000, '0);
    send_word(MODE_QUERY, 20'd6001, '0);
    send_word(MODE_QUERY, '1, '0);
    send_word(MODE_QUERY, 20'd3000, '0);
    send_word(MODE_APPEND, '1, '1);
    send_word(MODE_QUERY, 20'hFFFFE, '0);
    send_word(MODE_APPEND, '1, '1);
    send_word(MODE_CLEAR, '1, '1);
    send_word(MODE_APPEND, '0, '0);
    send_word(MODE_QUERY, '0, '0);
    send_word(MODE_QUERY, 20'd5, '0);
    send_word(MODE_CLEAR, '0, '0);

    // Random part, one phase per idling pattern, each with its own masses:
    // both full scale, no propellant, propellant heavier than the motor, and
    // a zero total with random propellant. The first phase opens with a curve
    // long enough to fill the table; the third holds the receiver off for a
    // long stretch so the block backs up into its input.
    run_phase(0, 0, '1, '1, 135, 1'b0, 1'b1);
    run_phase(67, 0, '1, '0, 135, 1'b0, 1'b0);
    run_phase(0, 67, 24'd300, '1, 135, 1'b1, 1'b0);
    run_phase(30, 30, '0, $urandom, 135, 1'b0, 1'b0);

    pause_until_drained();
    repeat (150) @(negedge clk);

    $display("%0d words: %0d stored, %0d table-full, %0d out-of-order, %0d clears, %0d unused.",
             words_sent, ledger.n_stored, ledger.n_full, ledger.n_not_inc,
             ledger.n_clear, ledger.n_unused);
    $display("%0d queries (%0d empty), %0d results checked, %0d hold-offs, %0d cycles.",
             ledger.n_query, ledger.n_no_data, ledger.checked, hold_count, cycle_count);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
